// File: design/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, expr, msg)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// File: design/hlc_pkg.sv
// Types and constants of the line clipper.
package hlc_pkg;
	localparam int FRAC_BITS = 16;
	localparam int COORD_W = 32;
	localparam int SCREEN_W = 14;
	localparam int PIX_W = 30;
	localparam int NPLANE = 6;
	localparam int NUM_W = COORD_W + 1;
	localparam int DEN_W = COORD_W + 2;
	localparam int TR_W = COORD_W + 3;
	localparam int T_W = FRAC_BITS + 1;
	localparam int TSTEPS = FRAC_BITS + 1;
	localparam int NSTEPS = FRAC_BITS + 15;
	localparam int PROD_W = NUM_W + FRAC_BITS;
	localparam int SV_W = COORD_W + 2;
	localparam int PV_W = SV_W + SCREEN_W + 1;
	localparam int QDEPTH = 4;
	localparam int QAW = 2;

	typedef enum logic [1:0] {
		ST_VISIBLE = 2'd0,
		ST_CLIPPED = 2'd1,
		ST_WZERO = 2'd2,
		ST_NOSCREEN = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		REG_WIDTH = 1'b0,
		REG_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] start_x;
		logic signed [COORD_W-1:0] start_y;
		logic signed [COORD_W-1:0] start_z;
		logic signed [COORD_W-1:0] start_w;
		logic signed [COORD_W-1:0] end_x;
		logic signed [COORD_W-1:0] end_y;
		logic signed [COORD_W-1:0] end_z;
		logic signed [COORD_W-1:0] end_w;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [PIX_W-1:0] pixel_start_x;
		logic [PIX_W-1:0] pixel_start_y;
		logic [PIX_W-1:0] pixel_end_x;
		logic [PIX_W-1:0] pixel_end_y;
	} out_item_t;

	typedef struct packed {
		logic reject;
		logic [NPLANE-1:0] enter;
		logic [NPLANE-1:0] leave;
		logic [NPLANE-1:0][NUM_W-1:0] num;
		logic [NPLANE-1:0][DEN_W-1:0] den;
		logic [2:0][COORD_W-1:0] a;
		logic [2:0][COORD_W-1:0] b;
	} clip_t;
endpackage

// File: design/hlc_front.sv
// Front end: accepts segments and forms plane values and crossing classes.
module hlc_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input hlc_pkg::in_item_t in_data,
	output logic push_valid,
	input logic push_ready,
	output hlc_pkg::clip_t push_data
);
	import hlc_pkg::*;

	logic v_s1;
	clip_t ent_s1;
	clip_t ent_d;

	assign in_ready = !v_s1 || push_ready;
	assign push_valid = v_s1;
	assign push_data = ent_s1;

	always_comb begin : c_class
		logic [NUM_W-1:0] x0, y0, z0, w0, x1, y1, z1, w1;
		logic [NPLANE-1:0][NUM_W-1:0] fa, fb;
		logic [NUM_W-1:0] ma, mb;
		x0 = {in_data.start_x[COORD_W-1], in_data.start_x};
		y0 = {in_data.start_y[COORD_W-1], in_data.start_y};
		z0 = {in_data.start_z[COORD_W-1], in_data.start_z};
		w0 = {in_data.start_w[COORD_W-1], in_data.start_w};
		x1 = {in_data.end_x[COORD_W-1], in_data.end_x};
		y1 = {in_data.end_y[COORD_W-1], in_data.end_y};
		z1 = {in_data.end_z[COORD_W-1], in_data.end_z};
		w1 = {in_data.end_w[COORD_W-1], in_data.end_w};
		fa[0] = x0 + w0; fb[0] = x1 + w1;
		fa[1] = w0 - x0; fb[1] = w1 - x1;
		fa[2] = y0 + w0; fb[2] = y1 + w1;
		fa[3] = w0 - y0; fb[3] = w1 - y1;
		fa[4] = z0; fb[4] = z1;
		fa[5] = w0 - z0; fb[5] = w1 - z1;
		ent_d.reject = 1'b0;
		for (int p = 0; p < NPLANE; p++) begin
			ma = fa[p][NUM_W-1] ? NUM_W'(-fa[p]) : fa[p];
			mb = fb[p][NUM_W-1] ? NUM_W'(-fb[p]) : fb[p];
			ent_d.reject = ent_d.reject | (fa[p][NUM_W-1] & fb[p][NUM_W-1]);
			ent_d.enter[p] = fa[p][NUM_W-1] & !fb[p][NUM_W-1];
			ent_d.leave[p] = !fa[p][NUM_W-1] & fb[p][NUM_W-1];
			ent_d.num[p] = ma;
			ent_d.den[p] = DEN_W'(ma) + DEN_W'(mb);
		end
		ent_d.a[0] = in_data.start_x;
		ent_d.a[1] = in_data.start_y;
		ent_d.a[2] = in_data.start_w;
		ent_d.b[0] = in_data.end_x;
		ent_d.b[1] = in_data.end_y;
		ent_d.b[2] = in_data.end_w;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			ent_s1 <= ent_d;
		end
	end
endmodule

// File: design/hlc_queue.sv
// Short queue between the front end and the back end.
module hlc_queue (
	input logic clk,
	input logic arst_n,
	input logic push_valid,
	output logic push_ready,
	input hlc_pkg::clip_t push_data,
	output logic pop_valid,
	input logic pop_ready,
	output hlc_pkg::clip_t pop_data
);
	import hlc_pkg::*;

	clip_t mem_q [QDEPTH];
	logic [QAW-1:0] wr_q, rd_q;
	logic [QAW:0] cnt_q;
	logic push, pop;

	assign push_ready = cnt_q != (QAW+1)'(QDEPTH);
	assign pop_valid = cnt_q != '0;
	assign pop_data = mem_q[rd_q];
	assign push = push_valid && push_ready;
	assign pop = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end
endmodule

// File: design/hlc_back.sv
// Back end: clip parameters, interpolation, perspective divide and pixel mapping.
module hlc_back (
	input logic clk,
	input logic arst_n,
	input logic pop_valid,
	output logic pop_ready,
	input hlc_pkg::clip_t pop_data,
	input logic [hlc_pkg::SCREEN_W-1:0] width,
	input logic [hlc_pkg::SCREEN_W-1:0] height,
	output logic out_valid,
	input logic out_ready,
	output hlc_pkg::out_item_t out_data
);
	import hlc_pkg::*;

	typedef struct packed {
		clip_t c;
		logic [NPLANE-1:0][TR_W-1:0] r;
		logic [NPLANE-1:0][T_W-1:0] q;
	} tdiv_t;

	typedef struct packed {
		logic clipped;
		logic [T_W-1:0] t0;
		logic [T_W-1:0] t1;
		logic [2:0][COORD_W-1:0] a;
		logic [2:0][COORD_W-1:0] b;
	} sel_t;

	typedef struct packed {
		logic neg;
		logic full;
		logic [PROD_W-1:0] prod;
		logic [COORD_W-1:0] a;
		logic [COORD_W-1:0] b;
	} lerp_t;

	typedef struct packed {
		logic clipped;
		lerp_t [5:0] l;
	} mul_t;

	typedef struct packed {
		logic clipped;
		logic wz;
		logic [5:0][COORD_W-1:0] p;
	} pts_t;

	typedef struct packed {
		logic clipped;
		logic wz;
		logic [3:0] neg;
		logic [3:0] sat;
		logic [3:0][COORD_W-1:0] num;
		logic [3:0][COORD_W-1:0] den;
		logic [3:0][COORD_W:0] r;
		logic [3:0][NSTEPS-1:0] q;
	} ndiv_t;

	typedef struct packed {
		logic clipped;
		logic wz;
		logic [3:0][SV_W-1:0] v;
	} ndc_t;

	typedef struct packed {
		logic clipped;
		logic wz;
		logic [3:0][PV_W-1:0] v;
	} pix_t;

	logic en;
	tdiv_t tdiv_q [TSTEPS+1];
	tdiv_t tdiv_d [TSTEPS+1];
	logic [TSTEPS:0] tdiv_v_q;
	sel_t sel_s1, sel_d;
	mul_t mul_s2, mul_d;
	pts_t pts_s3, pts_d;
	ndiv_t ndiv_q [NSTEPS+1];
	ndiv_t ndiv_d [NSTEPS+1];
	logic [NSTEPS:0] ndiv_v_q;
	ndc_t ndc_s4, ndc_d;
	pix_t pix_s5, pix_d;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	out_item_t out_d;

	assign en = !out_valid || out_ready;
	assign pop_ready = en;

	always_comb begin : c_tload
		tdiv_d[0].c = pop_data;
		for (int p = 0; p < NPLANE; p++) begin
			tdiv_d[0].r[p] = TR_W'(pop_data.num[p]);
			tdiv_d[0].q[p] = '0;
		end
	end

	for (genvar j = 0; j < TSTEPS; j++) begin : g_tstep
		always_comb begin : c_tstep
			logic [TR_W-1:0] rr;
			tdiv_d[j+1] = tdiv_q[j];
			for (int p = 0; p < NPLANE; p++) begin
				rr = (j == 0) ? tdiv_q[j].r[p] : {tdiv_q[j].r[p][TR_W-2:0], 1'b0};
				if (rr >= TR_W'(tdiv_q[j].c.den[p])) begin
					tdiv_d[j+1].r[p] = rr - TR_W'(tdiv_q[j].c.den[p]);
					tdiv_d[j+1].q[p] = {tdiv_q[j].q[p][T_W-2:0], 1'b1};
				end else begin
					tdiv_d[j+1].r[p] = rr;
					tdiv_d[j+1].q[p] = {tdiv_q[j].q[p][T_W-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin : c_sel
		logic [T_W-1:0] t;
		logic up;
		sel_d.t0 = '0;
		sel_d.t1 = T_W'(1) << FRAC_BITS;
		for (int p = 0; p < NPLANE; p++) begin
			up = {tdiv_q[TSTEPS].r[p], 1'b0} >= (TR_W+1)'(tdiv_q[TSTEPS].c.den[p]);
			t = tdiv_q[TSTEPS].q[p] + T_W'(up);
			if (tdiv_q[TSTEPS].c.enter[p] && t > sel_d.t0) begin
				sel_d.t0 = t;
			end
			if (tdiv_q[TSTEPS].c.leave[p] && t < sel_d.t1) begin
				sel_d.t1 = t;
			end
		end
		sel_d.clipped = tdiv_q[TSTEPS].c.reject || (sel_d.t0 > sel_d.t1);
		sel_d.a = tdiv_q[TSTEPS].c.a;
		sel_d.b = tdiv_q[TSTEPS].c.b;
	end

	always_comb begin : c_mul
		logic [NUM_W-1:0] d, m;
		logic [T_W-1:0] t;
		mul_d.clipped = sel_s1.clipped;
		for (int e = 0; e < 2; e++) begin
			for (int c = 0; c < 3; c++) begin
				t = (e == 0) ? sel_s1.t0 : sel_s1.t1;
				d = {sel_s1.b[c][COORD_W-1], sel_s1.b[c]} - {sel_s1.a[c][COORD_W-1], sel_s1.a[c]};
				m = d[NUM_W-1] ? NUM_W'(-d) : d;
				mul_d.l[e*3+c].neg = d[NUM_W-1];
				mul_d.l[e*3+c].full = t[FRAC_BITS];
				mul_d.l[e*3+c].prod = PROD_W'(m) * PROD_W'(t[FRAC_BITS-1:0]);
				mul_d.l[e*3+c].a = sel_s1.a[c];
				mul_d.l[e*3+c].b = sel_s1.b[c];
			end
		end
	end

	always_comb begin : c_lerp
		logic [PROD_W-1:0] sum;
		logic [NUM_W-1:0] pp, as, res;
		pts_d.clipped = mul_s2.clipped;
		for (int k = 0; k < 6; k++) begin
			sum = mul_s2.l[k].prod + (PROD_W'(1) << (FRAC_BITS - 1));
			pp = sum[PROD_W-1:FRAC_BITS];
			as = {mul_s2.l[k].a[COORD_W-1], mul_s2.l[k].a};
			res = mul_s2.l[k].neg ? as - pp : as + pp;
			pts_d.p[k] = mul_s2.l[k].full ? mul_s2.l[k].b : res[COORD_W-1:0];
		end
		pts_d.wz = (pts_d.p[2] == '0) || (pts_d.p[5] == '0);
	end

	always_comb begin : c_nload
		logic [COORD_W-1:0] x, w;
		ndiv_d[0].clipped = pts_s3.clipped;
		ndiv_d[0].wz = pts_s3.wz;
		for (int i = 0; i < 4; i++) begin
			x = pts_s3.p[(i/2)*3 + (i%2)];
			w = pts_s3.p[(i/2)*3 + 2];
			ndiv_d[0].num[i] = x[COORD_W-1] ? COORD_W'(-x) : x;
			ndiv_d[0].den[i] = w[COORD_W-1] ? COORD_W'(-w) : w;
			ndiv_d[0].neg[i] = x[COORD_W-1] ^ w[COORD_W-1];
			ndiv_d[0].sat[i] = (COORD_W+NSTEPS-FRAC_BITS)'(ndiv_d[0].num[i]) >=
				{ndiv_d[0].den[i], {(NSTEPS-FRAC_BITS){1'b0}}};
			ndiv_d[0].r[i] = (COORD_W+1)'(ndiv_d[0].num[i] >> (NSTEPS - FRAC_BITS));
			ndiv_d[0].q[i] = '0;
		end
	end

	for (genvar k = 0; k < NSTEPS; k++) begin : g_nstep
		always_comb begin : c_nstep
			logic [NSTEPS-1:0] nvec;
			logic [COORD_W:0] rr;
			ndiv_d[k+1] = ndiv_q[k];
			for (int i = 0; i < 4; i++) begin
				nvec = {ndiv_q[k].num[i][NSTEPS-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
				rr = {ndiv_q[k].r[i][COORD_W-1:0], nvec[NSTEPS-1-k]};
				if (rr >= {1'b0, ndiv_q[k].den[i]}) begin
					ndiv_d[k+1].r[i] = rr - {1'b0, ndiv_q[k].den[i]};
					ndiv_d[k+1].q[i] = {ndiv_q[k].q[i][NSTEPS-2:0], 1'b1};
				end else begin
					ndiv_d[k+1].r[i] = rr;
					ndiv_d[k+1].q[i] = {ndiv_q[k].q[i][NSTEPS-2:0], 1'b0};
				end
			end
		end
	end

	always_comb begin : c_ndc
		logic up;
		logic [COORD_W-1:0] ndc;
		logic [SV_W-1:0] s;
		ndc_d.clipped = ndiv_q[NSTEPS].clipped;
		ndc_d.wz = ndiv_q[NSTEPS].wz;
		for (int i = 0; i < 4; i++) begin
			up = {ndiv_q[NSTEPS].r[i], 1'b0} >= (COORD_W+2)'(ndiv_q[NSTEPS].den[i]);
			ndc = ndiv_q[NSTEPS].sat[i] ? (COORD_W'(1) << NSTEPS) :
				COORD_W'(ndiv_q[NSTEPS].q[i]) + COORD_W'(up);
			s = ndiv_q[NSTEPS].neg[i] ? SV_W'(-SV_W'(ndc)) : SV_W'(ndc);
			ndc_d.v[i] = (i % 2 == 0) ? (SV_W'(1) << FRAC_BITS) + s : (SV_W'(1) << FRAC_BITS) - s;
		end
	end

	always_comb begin : c_pix
		logic signed [PV_W-1:0] wx, hy;
		wx = PV_W'($signed({1'b0, width}));
		hy = PV_W'($signed({1'b0, height}));
		pix_d.clipped = ndc_s4.clipped;
		pix_d.wz = ndc_s4.wz;
		for (int i = 0; i < 4; i++) begin
			pix_d.v[i] = PV_W'($signed(ndc_s4.v[i])) * ((i % 2 == 0) ? wx : hy);
		end
	end

	always_comb begin : c_out
		logic [PV_W-1:0] rr;
		logic [3:0][PIX_W-1:0] px;
		for (int i = 0; i < 4; i++) begin
			rr = (pix_s5.v[i] + PV_W'(1)) >> 1;
			if (pix_s5.v[i][PV_W-1] || pix_s5.v[i] == '0) begin
				px[i] = '0;
			end else if (rr > PV_W'({PIX_W{1'b1}})) begin
				px[i] = '1;
			end else begin
				px[i] = rr[PIX_W-1:0];
			end
		end
		out_d.status = ST_VISIBLE;
		if (pix_s5.clipped) begin
			out_d.status = ST_CLIPPED;
		end else if (width == '0 || height == '0) begin
			out_d.status = ST_NOSCREEN;
		end else if (pix_s5.wz) begin
			out_d.status = ST_WZERO;
		end
		if (out_d.status == ST_VISIBLE) begin
			out_d.pixel_start_x = px[0];
			out_d.pixel_start_y = px[1];
			out_d.pixel_end_x = px[2];
			out_d.pixel_end_y = px[3];
		end else begin
			out_d.pixel_start_x = '0;
			out_d.pixel_start_y = '0;
			out_d.pixel_end_x = '0;
			out_d.pixel_end_y = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tdiv_v_q <= '0;
			ndiv_v_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			tdiv_v_q <= {tdiv_v_q[TSTEPS-1:0], pop_valid};
			v_s1 <= tdiv_v_q[TSTEPS];
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			ndiv_v_q <= {ndiv_v_q[NSTEPS-1:0], v_s3};
			v_s4 <= ndiv_v_q[NSTEPS];
			v_s5 <= v_s4;
			out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j <= TSTEPS; j++) begin
				tdiv_q[j] <= (j == 0) ? tdiv_d[0] : tdiv_d[j];
			end
			sel_s1 <= sel_d;
			mul_s2 <= mul_d;
			pts_s3 <= pts_d;
			for (int k = 0; k <= NSTEPS; k++) begin
				ndiv_q[k] <= ndiv_d[k];
			end
			ndc_s4 <= ndc_d;
			pix_s5 <= pix_d;
			out_data <= out_d;
		end
	end
endmodule

// File: design/homogeneous_line_clip_to_pixel.sv
// Top level of the line clipper: front end, queue, back end and screen registers.
// Throughput: one segment per cycle while out_ready does not hold the output; the
// back end is a stall-as-a-whole pipeline with one bit of every clip-parameter and
// perspective divide resolved per stage.
// A four-entry queue lets the front end keep accepting while the output is held.
// Reset (arst_n low, asynchronous) empties the pipeline and loads 1920 x 1080.
`include "assert_macros.svh"
module homogeneous_line_clip_to_pixel (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input hlc_pkg::in_item_t in_data,
	output logic out_valid,
	input logic out_ready,
	output hlc_pkg::out_item_t out_data,
	input logic cfg_we,
	input logic [0:0] cfg_index,
	input logic [hlc_pkg::SCREEN_W-1:0] cfg_data
);
	import hlc_pkg::*;

	logic [SCREEN_W-1:0] width_q, height_q;
	logic push_valid, push_ready, pop_valid, pop_ready;
	clip_t push_data, pop_data;
	logic out_pix_zero;

	assign out_pix_zero = out_data.pixel_start_x == '0 && out_data.pixel_start_y == '0 &&
		out_data.pixel_end_x == '0 && out_data.pixel_end_y == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SCREEN_W'(1920);
			height_q <= SCREEN_W'(1080);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH: width_q <= cfg_data;
				REG_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	hlc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data)
	);

	hlc_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data(push_data),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data)
	);

	hlc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data(pop_data),
		.width(width_q),
		.height(height_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	`ASSERT_ALWAYS(a_nonvisible_zero, clk, arst_n, !(out_valid && out_data.status != ST_VISIBLE) || out_pix_zero, "non-visible beat carries pixels")
	`ASSERT_ALWAYS(a_front_stall, clk, arst_n, in_ready || (push_valid && !push_ready), "front stalled without a full queue")
	`ASSERT_NEXT(a_cfg_width, clk, arst_n, cfg_we && cfg_index == REG_WIDTH, width_q == $past(cfg_data), "width write lost")
endmodule
